[rtl/tbr_pkg.sv]
// shared types and constants of the triangle bounding-box rasterizer
package tbr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int MAX_DIM   = 1024;
  localparam int DIM_W     = 11;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [15:0] vert_a_x;
    logic signed [15:0] vert_a_y;
    logic signed [15:0] vert_b_x;
    logic signed [15:0] vert_b_y;
    logic signed [15:0] vert_c_x;
    logic signed [15:0] vert_c_y;
    logic [31:0]        shade_a;
    logic [31:0]        shade_b;
    logic [31:0]        shade_c;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

[rtl/tbr_front.sv]
// front end: two-entry request queue ahead of the raster engine
module tbr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tbr_pkg::item_t  in_item,
  input  logic            pop,
  output tbr_pkg::head_t  head
);

  tbr_pkg::item_t ent_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;
  logic           take;

  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign take       = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (take) rd_ptr_r <= ~rd_ptr_r;
      case ({push, take})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/tbr_back.sv]
// raster engine: triangle setup, pixel scan, coverage and color interpolation
module tbr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbr_pkg::head_t              head,
  output logic                        pop,
  input  logic [tbr_pkg::DIM_W-1:0]   dim_w,
  input  logic [tbr_pkg::DIM_W-1:0]   dim_h,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_write_pixel,
  output logic [19:0]                 out_pixel_index,
  output logic [31:0]                 out_pixel_color,
  output logic                        out_scan_done
);

  localparam int DW = tbr_pkg::DIM_W;
  localparam int FB = tbr_pkg::FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_BOX   = 8'b0000_0010,
    S_DET   = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_UV    = 8'b0001_0000,
    S_TEST  = 8'b0010_0000,
    S_COLOR = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r;
  logic [3:0] step_r;
  logic [1:0] chan_r;
  logic       active_r;

  logic [DW-1:0] w_r, h_r;
  logic [DW-1:0] scan_x_r, scan_y_r, xlo_r, xhi_r, ylo_r, yhi_r;
  logic signed [15:0] ox_r, oy_r;
  logic signed [15:0] minx_r, maxx_r, miny_r, maxy_r;
  logic signed [16:0] abx_r, aby_r, acx_r, acy_r;
  logic [31:0] col_a_r, col_b_r, col_c_r;
  logic signed [35:0] det_r, d_r;
  logic signed [36:0] u_r, v_r;
  logic [DW:0]   remx_r, remy_r;
  logic [14:0]   qx_r, qy_r;
  logic          hit_r, done_r;
  logic [19:0]   idx_r;
  logic [31:0]   color_r;
  logic [7:0]    qch_r;
  logic signed [46:0] rem_r;

  logic          ov_r, owp_r, odone_r;
  logic          ov_nxt;
  logic [19:0]   oidx_r;
  logic [31:0]   ocol_r;

  // setup helpers
  logic signed [15:0] ax, ay, bx, by, cx, cy;
  assign ax = head.item.vert_a_x;
  assign ay = head.item.vert_a_y;
  assign bx = head.item.vert_b_x;
  assign by = head.item.vert_b_y;
  assign cx = head.item.vert_c_x;
  assign cy = head.item.vert_c_y;

  function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // bound mapping: floor((c + 1) * dim / 2)
  logic signed [15:0] bsel;
  logic [DW-1:0]      bdim;
  logic signed [17:0] bbias;
  logic signed [29:0] bprod;
  logic [DW-1:0]      bpix;
  always_comb begin
    case (step_r[1:0])
      2'd0:    begin bsel = minx_r; bdim = w_r; end
      2'd1:    begin bsel = maxx_r; bdim = w_r; end
      2'd2:    begin bsel = miny_r; bdim = h_r; end
      default: begin bsel = maxy_r; bdim = h_r; end
    endcase
    bbias = 18'(bsel) + 18'sd16384;
    bprod = bbias * $signed({1'b0, bdim});
    bpix  = (bprod < 0) ? '0 : bprod[FB+DW:FB+1];
  end

  // edge and barycentric products
  logic signed [17:0] pax, pay;
  logic signed [17:0] ma;
  logic signed [16:0] mb;
  logic signed [34:0] mprod;
  assign pax = $signed({3'b0, qx_r}) - 18'sd16384 - 18'(ox_r);
  assign pay = $signed({3'b0, qy_r}) - 18'sd16384 - 18'(oy_r);
  always_comb begin
    ma = 18'(abx_r);
    mb = acy_r;
    if (state_r == S_DET) begin
      ma = (step_r[0]) ? 18'(aby_r) : 18'(abx_r);
      mb = (step_r[0]) ? acx_r : acy_r;
    end else begin
      case (step_r[1:0])
        2'd0:    begin ma = pax; mb = acy_r; end
        2'd1:    begin ma = pay; mb = acx_r; end
        2'd2:    begin ma = pay; mb = abx_r; end
        default: begin ma = pax; mb = aby_r; end
      endcase
    end
    mprod = ma * mb;
  end

  // corner dividers, one quotient bit per cycle
  logic [DW:0] rx_sh, ry_sh;
  logic        gx, gy;
  assign rx_sh = {remx_r[DW-1:0], 1'b0};
  assign ry_sh = {remy_r[DW-1:0], 1'b0};
  assign gx    = rx_sh >= {1'b0, w_r};
  assign gy    = ry_sh >= {1'b0, h_r};

  // coverage test
  logic signed [35:0] d_abs;
  logic signed [36:0] u_s, v_s;
  logic               hit;
  logic [DW-1:0]      nx, ny;
  logic [21:0]        idx_full;
  always_comb begin
    d_abs = (det_r < 0) ? -det_r : det_r;
    u_s   = (det_r < 0) ? -u_r : u_r;
    v_s   = (det_r < 0) ? -v_r : v_r;
    hit   = !(u_s < 0 || v_s < 0 || v_s > 37'(d_abs) || (u_s + v_s) > 37'(d_abs));
    idx_full = ({11'b0, h_r - scan_y_r - 11'd1} * {11'b0, w_r}) + {11'b0, scan_x_r};
    nx = scan_x_r + 11'd1;
    ny = scan_y_r;
    if (nx >= xhi_r) begin
      nx = xlo_r;
      ny = scan_y_r + 11'd1;
    end
  end

  // color interpolation
  logic signed [36:0] wa;
  logic [7:0]         cbyte;
  logic signed [36:0] cw;
  logic signed [46:0] cprod;
  logic [2:0]         dbit;
  logic signed [46:0] dsh;
  logic               dge;
  always_comb begin
    wa = 37'(d_r) - u_r - v_r;
    case (step_r[1:0])
      2'd0:    begin cbyte = col_a_r[chan_r*8 +: 8]; cw = wa;  end
      2'd1:    begin cbyte = col_b_r[chan_r*8 +: 8]; cw = u_r; end
      default: begin cbyte = col_c_r[chan_r*8 +: 8]; cw = v_r; end
    endcase
    cprod = 47'($signed({1'b0, cbyte}) * cw);
    dbit  = 3'(4'd10 - step_r);
    dsh   = 47'(d_r) <<< dbit;
    dge   = rem_r >= dsh;
  end

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign pop      = (state_r == S_IDLE) && head.valid;

  always_comb begin
    ov_nxt = ov_r && !out_ready;
    if (state_r == S_OUT && out_free) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      chan_r   <= '0;
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            if (head.item.command == tbr_pkg::CMD_LOAD) begin
              active_r <= 1'b0;
              step_r   <= '0;
              state_r  <= S_BOX;
            end else if (active_r) begin
              step_r  <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_BOX: begin
          if (step_r == 4'd3) begin
            step_r  <= '0;
            state_r <= S_DET;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_DET: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'd2) begin
            if (det_r == 0 || xlo_r >= xhi_r || ylo_r >= yhi_r) begin
              state_r <= S_OUT;
            end else begin
              active_r <= 1'b1;
              state_r  <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (step_r == 4'd14) begin
            step_r  <= '0;
            state_r <= S_UV;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_UV: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'd3) begin
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          step_r <= '0;
          chan_r <= '0;
          if (ny >= yhi_r) active_r <= 1'b0;
          state_r <= hit ? S_COLOR : S_OUT;
        end
        S_COLOR: begin
          if (step_r == 4'd10) begin
            step_r <= '0;
            chan_r <= chan_r + 2'd1;
            if (chan_r == 2'd3) state_r <= S_OUT;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (head.valid && head.item.command == tbr_pkg::CMD_LOAD) begin
          w_r     <= dim_w;
          h_r     <= dim_h;
          ox_r    <= ax;
          oy_r    <= ay;
          abx_r   <= 17'(bx) - 17'(ax);
          aby_r   <= 17'(by) - 17'(ay);
          acx_r   <= 17'(cx) - 17'(ax);
          acy_r   <= 17'(cy) - 17'(ay);
          minx_r  <= min3(ax, bx, cx);
          maxx_r  <= max3(ax, bx, cx);
          miny_r  <= min3(ay, by, cy);
          maxy_r  <= max3(ay, by, cy);
          col_a_r <= head.item.shade_a;
          col_b_r <= head.item.shade_b;
          col_c_r <= head.item.shade_c;
        end else begin
          remx_r <= {1'b0, scan_x_r};
          remy_r <= {1'b0, scan_y_r};
        end
      end
      S_BOX: begin
        case (step_r[1:0])
          2'd0:    xlo_r <= bpix;
          2'd1:    xhi_r <= (bpix > w_r) ? w_r : bpix;
          2'd2:    ylo_r <= bpix;
          default: yhi_r <= (bpix > h_r) ? h_r : bpix;
        endcase
      end
      S_DET: begin
        if (step_r == 4'd0) det_r <= 36'(mprod);
        else if (step_r == 4'd1) det_r <= det_r - 36'(mprod);
        scan_x_r <= xlo_r;
        scan_y_r <= ylo_r;
        hit_r    <= 1'b0;
        idx_r    <= '0;
        color_r  <= '0;
        done_r   <= 1'b1;
      end
      S_DIV: begin
        remx_r <= gx ? (rx_sh - {1'b0, w_r}) : rx_sh;
        remy_r <= gy ? (ry_sh - {1'b0, h_r}) : ry_sh;
        qx_r   <= {qx_r[13:0], gx};
        qy_r   <= {qy_r[13:0], gy};
      end
      S_UV: begin
        case (step_r[1:0])
          2'd0:    u_r <= 37'(mprod);
          2'd1:    u_r <= u_r - 37'(mprod);
          2'd2:    v_r <= 37'(mprod);
          default: v_r <= v_r - 37'(mprod);
        endcase
      end
      S_TEST: begin
        d_r      <= d_abs;
        u_r      <= u_s;
        v_r      <= v_s;
        hit_r    <= hit;
        idx_r    <= idx_full[19:0];
        color_r  <= '0;
        done_r   <= (ny >= yhi_r);
        scan_x_r <= nx;
        scan_y_r <= ny;
      end
      S_COLOR: begin
        if (step_r == 4'd0) begin
          rem_r <= cprod + 47'(d_r >>> 1);
        end else if (step_r < 4'd3) begin
          rem_r <= rem_r + cprod;
        end else begin
          rem_r <= dge ? (rem_r - dsh) : rem_r;
          qch_r <= {qch_r[6:0], dge};
          if (step_r == 4'd10) color_r <= {qch_r[6:0], dge, color_r[31:8]};
        end
      end
      S_OUT: begin
        if (out_free) begin
          owp_r   <= hit_r;
          oidx_r  <= idx_r;
          ocol_r  <= color_r;
          odone_r <= done_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_write_pixel = owp_r;
  assign out_pixel_index = oidx_r;
  assign out_pixel_color = ocol_r;
  assign out_scan_done   = odone_r;

endmodule

[rtl/triangle_bbox_rasterizer.sv]
// top level of the triangle bounding-box rasterizer
//
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    tuser command, tdata vertices and colors
// out_      out  out_tvalid/out_tready  tuser write_pixel, tlast scan_done, tdata index, color
// cfg_      in   apb, pready high       frame_width at 0, frame_height at 4
//
// a load computes the bounding box and the determinant; a skipped triangle answers with one result
// an advance runs the corner dividers, the shared edge multiplier and the point-in-triangle test,
// and a covered pixel then goes through the color division of each of its four channels
// two requests queue ahead of the engine; a result waits in the output register
// reset (synchronous, rst_n low) empties the queue, ends the scan and clears the output valid
module triangle_bbox_rasterizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [0:0]   in_tuser,   // command
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, shade_a, shade_b, shade_c
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [0:0]   out_tuser,  // write_pixel
  output logic         out_tlast,  // scan_done
  output logic [55:0]  out_tdata,  // pixel_index, pixel_color, zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [tbr_pkg::DIM_W-1:0] DIM_CAP = tbr_pkg::DIM_W'(tbr_pkg::MAX_DIM);

  logic [tbr_pkg::DIM_W-1:0] frame_width_r, frame_height_r, eff_w, eff_h;
  tbr_pkg::item_t in_item;
  tbr_pkg::head_t head;
  logic           pop;
  logic [19:0]    pix_idx;
  logic [31:0]    pix_col;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {21'b0, frame_height_r} : {21'b0, frame_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd640;
      frame_height_r <= 11'd480;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) frame_height_r <= cfg_pwdata[10:0];
      else              frame_width_r  <= cfg_pwdata[10:0];
    end
  end

  assign eff_w = (frame_width_r > DIM_CAP) ? DIM_CAP : frame_width_r;
  assign eff_h = (frame_height_r > DIM_CAP) ? DIM_CAP : frame_height_r;

  assign in_item.command  = in_tuser[0];
  assign in_item.vert_a_x = in_tdata[15:0];
  assign in_item.vert_a_y = in_tdata[31:16];
  assign in_item.vert_b_x = in_tdata[47:32];
  assign in_item.vert_b_y = in_tdata[63:48];
  assign in_item.vert_c_x = in_tdata[79:64];
  assign in_item.vert_c_y = in_tdata[95:80];
  assign in_item.shade_a  = in_tdata[127:96];
  assign in_item.shade_b  = in_tdata[159:128];
  assign in_item.shade_c  = in_tdata[191:160];

  tbr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .pop      (pop),
    .head     (head)
  );

  tbr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .dim_w           (eff_w),
    .dim_h           (eff_h),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_write_pixel (out_tuser[0]),
    .out_pixel_index (pix_idx),
    .out_pixel_color (pix_col),
    .out_scan_done   (out_tlast)
  );

  assign out_tdata = {4'b0, pix_col, pix_idx};

endmodule
